// ===== hdl/ptom_pkg.sv =====
`timescale 1ns / 1ps

package ptom_pkg;

    // Field and datapath widths.
    localparam int CODE_W    = 24;  // raw ADC code
    localparam int OHMS_W    = 20;  // ohms in Q8 for any input code
    localparam int OHMS_FRAC = 8;   // fraction bits of the ohm value
    localparam int CODE_SHIFT = 9;  // ohms_q8 = code * 25 >> 9
    localparam int NUM_SHIFT = 5;   // x numerator = ohms_q8 * 32 + 62
    localparam int M_W       = 26;  // x numerator before division by 125
    localparam int X_W       = 19;  // x in Q16, up to 3.2
    localparam int ACC_W     = 32;  // Horner accumulator, Q16 degC
    localparam int PROD_W    = 60;  // 33 x 27 signed product
    localparam int Q_FRAC    = 16;
    localparam int TEMP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FRAMES_W  = 16;
    localparam int STEP_W    = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT  = 2'd2;

    localparam logic [CFG_W-1:0]        WINDOW_LOW_RESET  = 16'd0;
    localparam logic [CFG_W-1:0]        WINDOW_HIGH_RESET = 16'hFFFF;
    localparam logic signed [CFG_W-1:0] OVER_LIMIT_RESET  = 16'sd15360;

    // floor((256 * ohms_q8 + 500) / 1000) equals floor((32 * ohms_q8 + 62) / 125).
    localparam logic [M_W-1:0] X_NUM_OFFSET = 26'd62;

    // Division by 125 as a multiplication by ceil(2^32 / 125); exact for
    // numerators below 2^32 / 79, which covers every numerator used here.
    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125;
    localparam logic [M_W-1:0] RECIP_125 = M_W'(RECIP_FULL);

    // Cubic fit coefficients in Q16, rounded to nearest.
    localparam longint COEF_C0_FULL = -((64'sd193804 * 64'sd65536 + 64'sd500) / 64'sd1000);
    localparam longint COEF_C1_FULL = (64'sd960651 * 64'sd65536 + 64'sd5000) / 64'sd10000;
    localparam longint COEF_C2_FULL = (64'sd134673 * 64'sd65536 + 64'sd500) / 64'sd1000;
    localparam longint COEF_C3_FULL = -((64'sd369091 * 64'sd65536 + 64'sd5000) / 64'sd10000);
    localparam logic signed [ACC_W-1:0] COEF_C0 = ACC_W'(COEF_C0_FULL);
    localparam logic signed [ACC_W-1:0] COEF_C1 = ACC_W'(COEF_C1_FULL);
    localparam logic signed [ACC_W-1:0] COEF_C2 = ACC_W'(COEF_C2_FULL);
    localparam logic signed [ACC_W-1:0] COEF_C3 = ACC_W'(COEF_C3_FULL);

    localparam logic [STEP_W-1:0] HORNER_LAST = 2'd2;

    // From 4200 ohms upwards the fit lies far below -128 degC and keeps falling.
    localparam logic [CFG_W-1:0] LOW_SAT_OHMS = 16'd4200;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

    localparam logic [FRAMES_W-1:0] EMERGENCY_COUNT = 16'd3;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [CODE_W-1:0] resistance_code;
        logic              frame_last;
    } sample_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     reading_valid;
        logic                     over_limit;
        logic                     near_low_edge;
        logic                     emergency;
        logic [FRAMES_W-1:0]      overheat_frames;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0]        window_low_ohms;
        logic [CFG_W-1:0]        window_high_ohms;
        logic signed [CFG_W-1:0] over_limit_temp;
    } cfg_t;

    // One classified reading on its way to the conversion engine.
    typedef struct packed {
        logic [M_W-1:0] x_num;
        logic           in_window;
        logic           frame_last;
    } conv_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HORNER,
        BK_FINISH
    } back_state_t;

    function automatic logic signed [ACC_W-1:0] horner_coef(input logic [STEP_W-1:0] step);
        logic signed [ACC_W-1:0] coef;
        unique case (step)
            2'd0:    coef = COEF_C2;
            2'd1:    coef = COEF_C1;
            default: coef = COEF_C0;
        endcase
        return coef;
    endfunction

endpackage

// ===== hdl/ptom_front.sv =====
`timescale 1ns / 1ps

module ptom_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  ptom_pkg::sample_t   sample,
    input  ptom_pkg::cfg_t      cfg,
    input  logic                queue_full,
    output logic                push,
    output ptom_pkg::conv_job_t job
);
    import ptom_pkg::*;

    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    sample_t                hold_reg;
    sample_t                hold_next;
    logic                   accept;
    logic [CODE_W+4:0]      code_x25;
    logic [OHMS_W-1:0]      ohms_q8;
    logic [OHMS_W+3:0]      ohms_ext;
    logic [OHMS_W+3:0]      low_q8;
    logic [OHMS_W+3:0]      high_q8;

    assign sample_stall = hold_valid_reg && queue_full;
    assign accept       = sample_valid && !sample_stall;
    assign push         = hold_valid_reg && !queue_full;

    // code * 25 as shifts and adds, then scaled down to Q8 ohms.
    assign code_x25 = {5'b0, hold_reg.resistance_code}
                    + {2'b0, hold_reg.resistance_code, 3'b0}
                    + {1'b0, hold_reg.resistance_code, 4'b0};
    assign ohms_q8  = code_x25[CODE_SHIFT +: OHMS_W];
    assign ohms_ext = {4'b0, ohms_q8};
    assign low_q8   = {cfg.window_low_ohms, 8'b0};
    assign high_q8  = {cfg.window_high_ohms, 8'b0};

    always_comb
    begin
        job.in_window  = (ohms_ext >= low_q8) && (ohms_ext <= high_q8);
        job.x_num      = {1'b0, ohms_q8, 5'b0} + X_NUM_OFFSET;
        job.frame_last = hold_reg.frame_last;
    end

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_next       = sample;
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== hdl/ptom_queue.sv =====
`timescale 1ns / 1ps

module ptom_queue #(
    parameter int DEPTH = ptom_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ptom_pkg::conv_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                nonempty,
    output ptom_pkg::conv_job_t head_job
);
    import ptom_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    conv_job_t          slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign nonempty = count_reg != '0;
    assign head_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/ptom_back.sv =====
`timescale 1ns / 1ps

module ptom_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ptom_pkg::cfg_t      cfg,
    input  logic                low_write,
    input  logic                job_ready,
    input  ptom_pkg::conv_job_t job,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output ptom_pkg::result_t   result
);
    import ptom_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(1) << (Q_FRAC - 1);
    localparam logic signed [ACC_W-1:0]  HALF_Q8  = ACC_W'(1) << (OHMS_FRAC - 1);

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic                       low_pass_reg;
    logic                       low_pass_next;
    logic                       low_ok_reg;
    logic                       low_ok_next;
    logic signed [TEMP_W-1:0]   low_temp_reg;
    logic signed [TEMP_W-1:0]   low_temp_next;
    logic                       frame_any_reg;
    logic                       frame_any_next;
    logic [FRAMES_W-1:0]        consec_reg;
    logic [FRAMES_W-1:0]        consec_next;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    result_t                    result_reg;
    result_t                    result_next;
    conv_job_t                  job_reg;
    conv_job_t                  job_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic [X_W-1:0]             x_reg;
    logic [X_W-1:0]             x_next;

    logic [M_W-1:0]             low_x_num;
    logic [M_W-1:0]             x_num_sel;
    logic signed [ACC_W:0]      mul_a;
    logic signed [M_W:0]        mul_b;
    logic signed [PROD_W-1:0]   product;
    logic signed [PROD_W-1:0]   rounded_sum;
    logic signed [ACC_W-1:0]    acc_step;
    logic signed [ACC_W-1:0]    t_round;
    logic signed [ACC_W-1:0]    t_q8;
    logic signed [TEMP_W-1:0]   t_sat;
    logic signed [TEMP_W-1:0]   temp_item;
    logic signed [TEMP_W+1:0]   temp_ext;
    logic signed [TEMP_W+1:0]   low_edge_ext;
    logic                       over;
    logic                       near;
    logic                       any_over;
    logic [FRAMES_W-1:0]        frames_after;
    logic                       out_free;

    assign pop      = (state_reg == BK_IDLE) && job_ready;
    assign out_free = !result_valid_reg || !result_stall;

    // Lower window edge in Q8 ohms, then the same numerator as the front forms.
    // High bits lost in the cast only matter above the saturation limit.
    assign low_x_num = M_W'({cfg.window_low_ohms, 8'b0, 5'b0}) + X_NUM_OFFSET;
    assign x_num_sel = low_pass_reg ? low_x_num : job_reg.x_num;

    // One shared multiplier: reciprocal division first, then the Horner steps.
    assign mul_a = (state_reg == BK_DIV) ? $signed({7'b0, x_num_sel})
                                         : $signed({acc_reg[ACC_W-1], acc_reg});
    assign mul_b = (state_reg == BK_DIV) ? $signed({1'b0, RECIP_125})
                                         : $signed({8'b0, x_reg});
    assign product = mul_a * mul_b;

    assign rounded_sum = product + HALF_Q16;
    assign acc_step    = $signed(rounded_sum[Q_FRAC +: ACC_W]) + horner_coef(step_reg);

    // Q16 degC to Q8 with half-up rounding, then clamp to the field range.
    always_comb
    begin
        t_round = acc_reg + HALF_Q8;
        t_q8    = t_round >>> OHMS_FRAC;
        if (t_q8 > 32'sd32767)
        begin
            t_sat = TEMP_MAX;
        end
        else if (t_q8 < -32'sd32768)
        begin
            t_sat = TEMP_MIN;
        end
        else
        begin
            t_sat = t_q8[TEMP_W-1:0];
        end
    end

    always_comb
    begin
        temp_item    = job_reg.in_window ? t_sat : '0;
        temp_ext     = {{2{temp_item[TEMP_W-1]}}, temp_item};
        low_edge_ext = {{2{low_temp_reg[TEMP_W-1]}}, low_temp_reg} + 18'sd256;
        over         = temp_item > cfg.over_limit_temp;
        near         = job_reg.in_window && (temp_ext < low_edge_ext);
        any_over     = frame_any_reg || over;
        frames_after = any_over ? consec_reg + 1'b1 : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_ready)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                state_next = BK_HORNER;
            end
            BK_HORNER:
            begin
                if (step_reg == HORNER_LAST)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (low_pass_reg)
                begin
                    state_next = BK_DIV;
                end
                else if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step_next         = step_reg;
        acc_next          = acc_reg;
        x_next            = x_reg;
        job_next          = job_reg;
        low_pass_next     = low_pass_reg;
        low_ok_next       = low_ok_reg;
        low_temp_next     = low_temp_reg;
        frame_any_next    = frame_any_reg;
        consec_next       = consec_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_ready)
                begin
                    job_next      = job;
                    low_pass_next = !low_ok_reg;
                end
            end
            BK_DIV:
            begin
                x_next    = product[RECIP_SHIFT +: X_W];
                acc_next  = COEF_C3;
                step_next = '0;
            end
            BK_HORNER:
            begin
                acc_next  = acc_step;
                step_next = step_reg + 1'b1;
            end
            BK_FINISH:
            begin
                if (low_pass_reg)
                begin
                    low_temp_next = (cfg.window_low_ohms >= LOW_SAT_OHMS) ? TEMP_MIN : t_sat;
                    low_ok_next   = 1'b1;
                    low_pass_next = 1'b0;
                end
                else if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.temperature   = temp_item;
                    result_next.reading_valid = job_reg.in_window;
                    result_next.over_limit    = over;
                    result_next.near_low_edge = near;
                    if (job_reg.frame_last)
                    begin
                        frame_any_next              = 1'b0;
                        consec_next                 = frames_after;
                        result_next.emergency       = frames_after == EMERGENCY_COUNT;
                        result_next.overheat_frames = frames_after;
                    end
                    else
                    begin
                        frame_any_next              = any_over;
                        result_next.emergency       = 1'b0;
                        result_next.overheat_frames = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (low_write)
        begin
            low_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            step_reg         <= '0;
            low_pass_reg     <= 1'b0;
            low_ok_reg       <= 1'b0;
            frame_any_reg    <= 1'b0;
            consec_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            low_pass_reg     <= low_pass_next;
            low_ok_reg       <= low_ok_next;
            frame_any_reg    <= frame_any_next;
            consec_reg       <= consec_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        acc_reg      <= acc_next;
        x_reg        <= x_next;
        low_temp_reg <= low_temp_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == BK_FINISH) && !$past(low_pass_reg))
        else $error("result loaded outside the finish step of an item");

    a_emergency_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.emergency) |-> result_reg.overheat_frames == EMERGENCY_COUNT)
        else $error("emergency raised with a frame count other than three");

    a_horner_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_HORNER) |-> (step_reg <= HORNER_LAST))
        else $error("Horner step counter ran past the last coefficient");

    a_low_pass_return: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FINISH && low_pass_reg) |=> (state_reg == BK_DIV) && !low_pass_reg)
        else $error("low-edge pass did not hand over to the item conversion");
`endif

endmodule

// ===== hdl/pt1000_overheat_monitor.sv =====
`timescale 1ns / 1ps
// An accepted item goes from the front end holding register through the queue to the
// conversion engine, which first recomputes the lower window edge temperature when the
// item is the first after reset or a write to the window low register. One item at a time
// runs through one division step and three Horner steps on the shared multiplier.
// Reset (rst_n low, asynchronous) clears the frame state, empties the queue and loads the
// register defaults: window 0 to 65535 ohms, overheat limit 60 degC.

module pt1000_overheat_monitor #(
    parameter int QUEUE_DEPTH = ptom_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  ptom_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output ptom_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [ptom_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptom_pkg::CFG_W-1:0]       cfg_data
);
    import ptom_pkg::*;

    // Configuration registers. Writes must arrive only while the block is idle, which the
    // block itself does not enforce; the front and back ends read them directly.
    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       low_write;

    // Front end to queue, and queue to the conversion engine.
    logic       queue_full;
    logic       push;
    conv_job_t  push_job;
    logic       pop;
    logic       job_ready;
    conv_job_t  head_job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW_LOW:  cfg_next.window_low_ohms  = cfg_data;
                REG_WINDOW_HIGH: cfg_next.window_high_ohms = cfg_data;
                REG_OVER_LIMIT:  cfg_next.over_limit_temp  = $signed(cfg_data);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // A new lower window edge invalidates the cached edge temperature in the engine.
    assign low_write = cfg_write && (cfg_index == REG_WINDOW_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low_ohms  <= WINDOW_LOW_RESET;
            cfg_reg.window_high_ohms <= WINDOW_HIGH_RESET;
            cfg_reg.over_limit_temp  <= OVER_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end takes each item into a holding register, scales the code to ohms,
    // checks the window and forms the numerator of x.
    ptom_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cfg          (cfg_reg),
        .queue_full   (queue_full),
        .push         (push),
        .job          (push_job)
    );

    // A short queue lets the front end keep accepting while the engine is busy.
    ptom_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .nonempty (job_ready),
        .head_job (head_job)
    );

    // The back end evaluates the cubic fit on one multiplier, flags the reading,
    // keeps the frame counters and holds the result in an output register.
    ptom_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .low_write    (low_write),
        .job_ready    (job_ready),
        .job          (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import ptom_pkg::*;

    // Cubic PT1000 fit coefficients in Q16, each rounded to nearest from its decimal value.
    localparam longint FIT_C0 = -((longint'(193804) * 65536 + 500) / 1000);
    localparam longint FIT_C1 = (longint'(960651) * 65536 + 5000) / 10000;
    localparam longint FIT_C2 = (longint'(134673) * 65536 + 500) / 1000;
    localparam longint FIT_C3 = -((longint'(369091) * 65536 + 5000) / 10000);

    // The emergency flag marks exactly the third overheated frame in a row.
    localparam logic [FRAMES_W-1:0] EMERGENCY_STREAK = 16'd3;

    // Register index 3 is not decoded; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Handy raw codes. One ohm is 5242.88 codes, so the whole-hundred values land on
    // exact ohms, while the 1003 and 1004 ohm codes sit a fraction of an ohm above.
    localparam logic [CODE_W-1:0] CODE_ZERO       = 24'd0;
    localparam logic [CODE_W-1:0] CODE_FULL       = 24'hFFFFFF;
    localparam logic [CODE_W-1:0] CODE_1000_OHMS  = 24'd5242880;
    localparam logic [CODE_W-1:0] CODE_BELOW_1000 = 24'd5242879;
    localparam logic [CODE_W-1:0] CODE_1003_OHMS  = 24'd5258609;
    localparam logic [CODE_W-1:0] CODE_1004_OHMS  = 24'd5263852;
    localparam logic [CODE_W-1:0] CODE_1100_OHMS  = 24'd5767168;
    localparam logic [CODE_W-1:0] CODE_ABOVE_1100 = 24'd5767189;
    localparam logic [CODE_W-1:0] CODE_1300_OHMS  = 24'd6815744;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 100;
    localparam int DIRECTED_ROWS  = 32;

    // An invalid reading that is not over the limit and does not close a frame
    // produces an all-zero result.
    localparam result_t QUIET = '0;

    typedef enum bit [0:0] {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed table: either a register write or an item. Items
    // marked as typed carry their expected result in the table; the rest are
    // checked against the predictor.
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        sample_t              item;
        bit                   typed;
        result_t              want;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Reset settings. Code 0 is 0 ohms: the fit saturates at the bottom and,
        // with the window starting at 0 ohms, the reading sits on the low edge.
        '{ROW_ITEM, '0, '0, '{CODE_ZERO, 1'b0}, 1'b1,
          '{16'sh8000, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0}},
        '{ROW_ITEM, '0, '0, '{CODE_FULL, 1'b0}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b1}, 1'b0, QUIET},
        // A run of overheated frames up to the emergency, then a cool frame that ends it.
        '{ROW_ITEM, '0, '0, '{CODE_1300_OHMS, 1'b1}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b0}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1300_OHMS, 1'b1}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1300_OHMS, 1'b1}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b1}, 1'b0, QUIET},
        // Undecoded index, then the most negative limit and an inverted window.
        '{ROW_WRITE, REG_UNUSED, 16'h0000, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_OVER_LIMIT, 16'h8000, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_WINDOW_LOW, 16'd2000, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_WINDOW_HIGH, 16'd1000, '0, 1'b0, QUIET},
        // Every reading is invalid, yet its zero temperature is over the limit.
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b1}, 1'b1,
          '{16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{ROW_ITEM, '0, '0, '{CODE_FULL, 1'b1}, 1'b1,
          '{16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd2}},
        '{ROW_ITEM, '0, '0, '{CODE_ZERO, 1'b1}, 1'b1,
          '{16'sd0, 1'b0, 1'b1, 1'b0, 1'b1, 16'd3}},
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b0}, 1'b1,
          '{16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0}},
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b1}, 1'b1,
          '{16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd4}},
        // Top extremes: a single-point window at 65535 ohms and the highest limit.
        '{ROW_WRITE, REG_WINDOW_LOW, 16'hFFFF, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_WINDOW_HIGH, 16'hFFFF, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_OVER_LIMIT, 16'h7FFF, '0, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_FULL, 1'b1}, 1'b1, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_ZERO, 1'b0}, 1'b1, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_ZERO, 1'b1}, 1'b1, QUIET},
        // Narrow window of 1000 to 1100 ohms: both edges and the 1 K band above low.
        '{ROW_WRITE, REG_WINDOW_LOW, 16'd1000, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_WINDOW_HIGH, 16'd1100, '0, 1'b0, QUIET},
        '{ROW_WRITE, REG_OVER_LIMIT, 16'd2560, '0, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1000_OHMS, 1'b0}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_BELOW_1000, 1'b0}, 1'b1, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1100_OHMS, 1'b0}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_ABOVE_1100, 1'b0}, 1'b1, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1003_OHMS, 1'b0}, 1'b0, QUIET},
        '{ROW_ITEM, '0, '0, '{CODE_1004_OHMS, 1'b1}, 1'b0, QUIET}
    };

    // Every input is held at a known value from time zero.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sample_valid = 1'b0;
    sample_t              sample_item  = '0;
    logic                 result_stall = 1'b0;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 sample_stall;
    logic                 result_valid;
    result_t              result_item;

    // The predictor's own copy of the registers and of the frame state.
    logic [CFG_W-1:0]        win_low_ohms  = 16'd0;
    logic [CFG_W-1:0]        win_high_ohms = 16'hFFFF;
    logic signed [CFG_W-1:0] limit_degc    = 16'sd15360;
    bit                      frame_has_over = 1'b0;
    logic [FRAMES_W-1:0]     over_streak    = '0;

    // Results still owed by the block, oldest first.
    result_t expected_readings[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_ticket    = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    pt1000_overheat_monitor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Divide by 2^s, rounding halves towards plus infinity. The arithmetic shift
    // floors, which is exactly what the half-up rule needs for negative values too.
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Q8 ohms to Q8 degrees: x = R / 1000 ohm in Q16, then Horner's rule on the
    // cubic, then the Q16 to Q8 step and saturation to the 16-bit field.
    function automatic logic signed [TEMP_W-1:0] ohms_to_degc(longint unsigned ohms_q8);
        longint x;
        longint acc;
        x = longint'((ohms_q8 * 256 + 500) / 1000);
        acc = FIT_C3;
        acc = round_half_up(acc * x, Q_FRAC) + FIT_C2;
        acc = round_half_up(acc * x, Q_FRAC) + FIT_C1;
        acc = round_half_up(acc * x, Q_FRAC) + FIT_C0;
        acc = round_half_up(acc, 8);
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return acc[TEMP_W-1:0];
    endfunction

    // Works out the result of one accepted item and advances the frame state.
    function automatic result_t predict_reading(sample_t s);
        longint unsigned         ohms_q8;
        longint unsigned         low_q8;
        longint unsigned         high_q8;
        logic signed [TEMP_W-1:0] low_edge_temp;
        result_t                 r;
        ohms_q8 = 64'(s.resistance_code);
        ohms_q8 = (ohms_q8 * 25) >> CODE_SHIFT;
        low_q8  = {40'd0, win_low_ohms, 8'd0};
        high_q8 = {40'd0, win_high_ohms, 8'd0};
        r = '0;
        r.reading_valid = (ohms_q8 >= low_q8) && (ohms_q8 <= high_q8);
        r.temperature   = r.reading_valid ? ohms_to_degc(ohms_q8) : 16'sd0;
        low_edge_temp   = ohms_to_degc(low_q8);
        // An invalid reading still compares its zero against the limit.
        r.over_limit    = int'(r.temperature) > int'(limit_degc);
        r.near_low_edge = r.reading_valid && (int'(r.temperature) < int'(low_edge_temp) + 256);
        if (r.over_limit)
            frame_has_over = 1'b1;
        if (s.frame_last)
        begin
            // The streak counter wraps from 65535 to 0 like the hardware's.
            over_streak = frame_has_over ? over_streak + 16'd1 : 16'd0;
            r.emergency = (over_streak == EMERGENCY_STREAK);
            r.overheat_frames = over_streak;
            frame_has_over = 1'b0;
        end
        return r;
    endfunction

    // Offers one item, after an optional random gap, and waits for it to be taken.
    // The expected result is recorded at the acceptance edge so that the predictor
    // sees items in exactly the order the block does.
    task automatic push_sample(sample_t s, bit typed, result_t typed_want);
        int      gap;
        result_t predicted;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= s;
        do @(posedge clk); while (sample_stall);
        predicted = predict_reading(s);
        expected_readings.insert(expected_readings.size(), typed ? typed_want : predicted);
    endtask

    // Stops offering items and waits until every owed result has come out.
    // It always advances past a clock edge, so the valid line never gets two
    // assignments in one time step.
    task automatic drain_readings();
        sample_valid <= 1'b0;
        do @(posedge clk); while (expected_readings.size() != 0);
    endtask

    // One register write, ending with the enable low so back-to-back writes never
    // raise and lower the enable in the same step. The predictor's copy follows.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_WINDOW_LOW:  win_low_ohms  = value;
            REG_WINDOW_HIGH: win_high_ohms = value;
            REG_OVER_LIMIT:  limit_degc    = value;
            default:         ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: expected temp %0d valid %0b over %0b near %0b emerg %0b frames %0d, ",
                     what, want.temperature, want.reading_valid, want.over_limit,
                     want.near_low_edge, want.emergency, want.overheat_frames,
                     "got temp %0d valid %0b over %0b near %0b emerg %0b frames %0d",
                     got.temperature, got.reading_valid, got.over_limit,
                     got.near_low_edge, got.emergency, got.overheat_frames);
    endtask

    // Receiver side. A hold-off request from the stimulus makes this process keep
    // the stall high for a long, self-counted stretch; otherwise it stalls at random.
    always @(posedge clk)
    begin
        if (hold_served != hold_ticket)
        begin
            hold_served = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Every accepted result is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result with nothing expected", QUIET, result_item);
            else
            begin
                want = expected_readings.pop_front();
                if (result_item.temperature !== want.temperature ||
                    result_item.reading_valid !== want.reading_valid ||
                    result_item.over_limit !== want.over_limit ||
                    result_item.near_low_edge !== want.near_low_edge ||
                    result_item.emergency !== want.emergency ||
                    result_item.overheat_frames !== want.overheat_frames)
                    report_mismatch("result mismatch", want, result_item);
            end
        end
    end

    // Watchdog: a long stretch in which neither channel moves an item means the
    // block has hung, since even the longest receiver hold-off is far shorter.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pt1000_overheat_monitor regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        sample_t          s;
        int               k;
        int               phase;
        int               frame_len;
        int               items_left;
        logic [CFG_W-1:0] low;
        logic [CFG_W-1:0] high;
        logic [CFG_W-1:0] limit;
        logic [CFG_W-1:0] bound_ohms;
        longint           bound;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: register writes wait until the block has gone quiet.
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            if (DIRECTED[k].kind == ROW_WRITE)
            begin
                drain_readings();
                write_reg(DIRECTED[k].reg_index, DIRECTED[k].reg_value);
            end
            else
                push_sample(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].want);
        end

        // Random part. Phases come in pairs: receiver idling more, then sender
        // idling more, then no idling at all. The last phase uses fully random
        // register values; the others use windows and limits a real rack would.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_readings();
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == RANDOM_PHASES - 1)
            begin
                low   = CFG_W'($urandom_range(0, 65535));
                high  = CFG_W'($urandom_range(0, 65535));
                limit = CFG_W'($urandom_range(0, 65535));
            end
            else
            begin
                low   = CFG_W'($urandom_range(700, 1000));
                high  = CFG_W'($urandom_range(1200, 3200));
                limit = CFG_W'($urandom_range(0, 30720));
            end
            write_reg(REG_WINDOW_LOW, low);
            write_reg(REG_WINDOW_HIGH, high);
            write_reg(REG_OVER_LIMIT, limit);

            // Items are grouped into well-formed frames of one to eight readings,
            // with the occasional frame mark flipped so that broken frames occur too.
            items_left = PHASE_ITEMS;
            while (items_left > 0)
            begin
                frame_len = $urandom_range(1, 8);
                for (k = 0; k < frame_len && items_left > 0; k++)
                begin
                    items_left--;
                    case ($urandom_range(9))
                        0, 1:
                            s.resistance_code = CODE_W'($urandom_range(0, 24'hFFFFFF));
                        2:
                        begin
                            // A code within one step of either window edge.
                            bound_ohms = $urandom_range(1) ? win_low_ohms : win_high_ohms;
                            bound = (longint'(bound_ohms) * 131072 + 24) / 25
                                    + int'($urandom_range(2)) - 1;
                            if (bound < 0)
                                bound = 0;
                            else if (bound > 24'hFFFFFF)
                                bound = 24'hFFFFFF;
                            s.resistance_code = bound[CODE_W-1:0];
                        end
                        default:
                            // Roughly -25 to +110 degC, where the limits above bite.
                            s.resistance_code = CODE_W'($urandom_range(4700000, 7400000));
                    endcase
                    s.frame_last = (k == frame_len - 1) || (items_left == 0);
                    if ($urandom_range(9) == 0)
                        s.frame_last = 1'($urandom_range(1));

                    // With no idling on the sender, a long receiver hold-off fills
                    // the block and pushes the stall back to its input.
                    if (phase == 4 && items_left == 70)
                        hold_ticket++;
                    // Here the sender stops until everything owed has come out.
                    if (phase == 2 && items_left == 50)
                        drain_readings();

                    push_sample(s, 1'b0, QUIET);
                end
            end
        end

        // Let everything out, then watch a little longer for stray results.
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("pt1000_overheat_monitor regression: pass");
        else
            $display("pt1000_overheat_monitor regression: fail");
        $finish;
    end

endmodule
